// File: sv/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a consequent holds whenever an antecedent holds.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check a next-cycle consequent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/e2rm_pkg.sv
// ----------------------------------------------------------------------------
// e2rm_pkg
// Shared constants, types and tables for the Euler-to-matrix pipeline.
// ----------------------------------------------------------------------------
package e2rm_pkg;

  localparam int AngleBits   = 16;
  localparam int FracBits    = 14;
  localparam int OutW        = 16;
  localparam int CordicSteps = 28;
  localparam int CordicW     = 36;   // x/y datapath, Q.32 plus headroom
  localparam int PhaseW      = 32;
  localparam int QW          = FracBits + 2;  // value range -1..+1

  localparam logic signed [CordicW-1:0] CordicGain = 36'sd2608131496;
  localparam logic signed [PhaseW:0]    QuarterTurn = 33'sd1073741824;
  localparam logic signed [PhaseW:0]    HalfTurn    = 33'sd2147483648;

  typedef enum logic [2:0] {
    ORD_XYZ = 3'd0,
    ORD_YXZ = 3'd1,
    ORD_ZXY = 3'd2,
    ORD_ZYX = 3'd3,
    ORD_YZX = 3'd4,
    ORD_XZY = 3'd5
  } order_e;

  typedef logic signed [QW-1:0] q_t;

  function automatic logic signed [PhaseW:0] atan_turn(input int idx);
    logic signed [PhaseW:0] t;
    begin
      case (idx)
        0: t = 33'sd536870912;   1: t = 33'sd316933406;
        2: t = 33'sd167458907;   3: t = 33'sd85004756;
        4: t = 33'sd42667331;    5: t = 33'sd21354465;
        6: t = 33'sd10679838;    7: t = 33'sd5340245;
        8: t = 33'sd2670163;     9: t = 33'sd1335087;
        10: t = 33'sd667544;     11: t = 33'sd333772;
        12: t = 33'sd166886;     13: t = 33'sd83443;
        14: t = 33'sd41722;      15: t = 33'sd20861;
        16: t = 33'sd10430;      17: t = 33'sd5215;
        18: t = 33'sd2608;       19: t = 33'sd1304;
        20: t = 33'sd652;        21: t = 33'sd326;
        22: t = 33'sd163;        23: t = 33'sd81;
        24: t = 33'sd41;         25: t = 33'sd20;
        26: t = 33'sd10;         27: t = 33'sd5;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

  // Rounded Q product, floor shift.
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [2*QW-1:0] p;
    begin
      p = a * b + (2*QW)'(1 <<< (FracBits - 1));
      p = p >>> FracBits;
      return p[QW-1:0];
    end
  endfunction

  function automatic q_t clamp_q(input logic signed [QW+1:0] v);
    begin
      if (v > (QW+2)'(1 <<< FracBits)) return q_t'(1 <<< FracBits);
      else if (v < -(QW+2)'(1 <<< FracBits)) return -q_t'(1 <<< FracBits);
      else return v[QW-1:0];
    end
  endfunction

endpackage

// File: sv/euler_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Three binary angles and an axis order in, 3x3 rotation matrix in Q1.14 out.
// ----------------------------------------------------------------------------
//  channel   signals                                     direction
//  in        in_valid_i, in_stall_o, angle_*_i, order    sink
//  out       out_valid_o, out_stall_i, r*c*_o             source
//
// One item per cycle while the output is not stalled. The stages are 1 prep
// stage, 28 CORDIC stages (one micro-rotation each), 1 round stage, then 5
// matrix stages (pair products, triple products, sums, clamp, output register).
// Reset clears valid bits only. A stall at the output freezes the whole
// pipeline; in_stall_o follows out_stall_i while a result waits at the output.
module euler_to_rotation_matrix (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  angle_x_i,
  input  logic signed [15:0]  angle_y_i,
  input  logic signed [15:0]  angle_z_i,
  input  logic [2:0]          rotation_order_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  r0c0_o,
  output logic signed [15:0]  r0c1_o,
  output logic signed [15:0]  r0c2_o,
  output logic signed [15:0]  r1c0_o,
  output logic signed [15:0]  r1c1_o,
  output logic signed [15:0]  r1c2_o,
  output logic signed [15:0]  r2c0_o,
  output logic signed [15:0]  r2c1_o,
  output logic signed [15:0]  r2c2_o
);
  import e2rm_pkg::*;
  `include "assert_macros.svh"

  localparam int NC = CordicSteps;
  localparam int NS = NC + 7;  // valid stages: prep, cordic, round, 5 matrix

  logic [NS-1:0] vld_q;
  logic          adv;

  // Pipeline advances unless the output register holds an untaken result.
  assign adv        = !(vld_q[NS-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // ---------------- stage 0: phase fold ----------------
  logic signed [CordicW-1:0] x_q [3][NC+1];
  logic signed [CordicW-1:0] y_q [3][NC+1];
  logic signed [PhaseW:0]    z_q [3][NC+1];
  logic                      flp_q [3][NC+1];
  logic [2:0]                ord_q [NC+4];

  logic signed [15:0] ang_in [3];
  assign ang_in[0] = angle_x_i;
  assign ang_in[1] = angle_y_i;
  assign ang_in[2] = angle_z_i;

  for (genvar a = 0; a < 3; a++) begin : g_ax
    logic signed [PhaseW:0] z0;
    logic                   f0;
    logic signed [PhaseW:0] z0_fold;
    always_comb begin
      z0 = (PhaseW+1)'($signed({ang_in[a], {(PhaseW - AngleBits){1'b0}}}));
      f0 = 1'b0;
      z0_fold = z0;
      if (z0 > QuarterTurn) begin
        z0_fold = z0 - HalfTurn;
        f0 = 1'b1;
      end else if (z0 < -QuarterTurn) begin
        z0_fold = z0 + HalfTurn;
        f0 = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        x_q[a][0]    <= CordicGain;
        y_q[a][0]    <= '0;
        z_q[a][0]    <= z0_fold;
        flp_q[a][0]  <= f0;
      end
    end

    // ---------------- CORDIC stages ----------------
    for (genvar i = 0; i < NC; i++) begin : g_st
      logic signed [CordicW-1:0] dx, dy;
      assign dx = y_q[a][i] >>> i;
      assign dy = x_q[a][i] >>> i;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          flp_q[a][i+1] <= flp_q[a][i];
          if (z_q[a][i] >= 0) begin
            x_q[a][i+1] <= x_q[a][i] - dx;
            y_q[a][i+1] <= y_q[a][i] + dy;
            z_q[a][i+1] <= z_q[a][i] - atan_turn(i);
          end else begin
            x_q[a][i+1] <= x_q[a][i] + dx;
            y_q[a][i+1] <= y_q[a][i] - dy;
            z_q[a][i+1] <= z_q[a][i] + atan_turn(i);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ord_q[0] <= rotation_order_i;
      for (int k = 1; k < NC + 4; k++) ord_q[k] <= ord_q[k-1];
    end
  end

  // ---------------- round stage: cos/sin ----------------
  q_t cs_q [3];
  q_t sn_q [3];

  function automatic q_t rnd_cl(input logic signed [CordicW-1:0] v, input logic neg);
    logic signed [CordicW-1:0] w;
    logic signed [CordicW-1:0] r;
    begin
      w = neg ? -v : v;
      r = (w + (CordicW)'(1 <<< (31 - FracBits))) >>> (32 - FracBits);
      if (r > (CordicW)'(1 <<< FracBits)) return q_t'(1 <<< FracBits);
      else if (r < -(CordicW)'(1 <<< FracBits)) return -q_t'(1 <<< FracBits);
      else return r[QW-1:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        cs_q[a] <= rnd_cl(x_q[a][NC], flp_q[a][NC]);
        sn_q[a] <= rnd_cl(y_q[a][NC], flp_q[a][NC]);
      end
    end
  end

  // ---------------- matrix stage 1: pair products ----------------
  // Order selects which axes form the four pair products and the "third" angle.
  q_t p_q [4];
  q_t s1_q [3];
  q_t m1_q [5];  // single products used directly

  always_ff @(posedge clk_i) begin
    q_t ca, sa, cb, sb;
    if (adv) begin
      ca = cs_q[0]; sa = sn_q[0]; cb = cs_q[2]; sb = sn_q[2];
      if (ord_q[NC+1] == ORD_YXZ || ord_q[NC+1] == ORD_ZXY) begin
        ca = cs_q[1]; sa = sn_q[1];
      end else if (ord_q[NC+1] == ORD_YZX || ord_q[NC+1] == ORD_XZY) begin
        cb = cs_q[1]; sb = sn_q[1];
      end
      p_q[0] <= qmul(ca, cb);
      p_q[1] <= qmul(ca, sb);
      p_q[2] <= qmul(sa, cb);
      p_q[3] <= qmul(sa, sb);
      m1_q[0] <= qmul(cs_q[1], cs_q[2]);  // cy cz
      m1_q[1] <= qmul(cs_q[1], sn_q[2]);  // cy sz
      m1_q[2] <= qmul(sn_q[0], cs_q[1]);  // sx cy
      m1_q[3] <= qmul(cs_q[0], cs_q[1]);  // cx cy
      m1_q[4] <= qmul(cs_q[0], sn_q[1]);  // cx sy
      for (int a = 0; a < 3; a++) begin
        s1_q[a] <= sn_q[a];
      end
    end
  end

  // extra single products (second bank, same stage depth via registers)
  q_t m1b_q [4];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1b_q[0] <= qmul(cs_q[0], sn_q[2]);  // cx sz
      m1b_q[1] <= qmul(cs_q[0], cs_q[2]);  // cx cz
      m1b_q[2] <= qmul(sn_q[1], cs_q[2]);  // sy cz
      m1b_q[3] <= qmul(sn_q[0], cs_q[2]);  // sx cz
    end
  end

  // ---------------- matrix stage 2: triple products ----------------
  q_t p2_q [4];
  q_t t_q  [4];
  q_t s2_q [3];
  q_t m2_q [9];

  always_ff @(posedge clk_i) begin
    q_t s3;
    if (adv) begin
      case (ord_q[NC+2])
        ORD_XYZ, ORD_ZYX: s3 = s1_q[1];
        ORD_YXZ, ORD_ZXY: s3 = s1_q[0];
        default:          s3 = s1_q[2];
      endcase
      for (int k = 0; k < 4; k++) begin
        t_q[k]  <= qmul(p_q[k], s3);
        p2_q[k] <= p_q[k];
      end
      m2_q[0] <= m1_q[0]; m2_q[1] <= m1_q[1]; m2_q[2] <= m1_q[2];
      m2_q[3] <= m1_q[3]; m2_q[4] <= m1_q[4];
      m2_q[5] <= m1b_q[0]; m2_q[6] <= m1b_q[1]; m2_q[7] <= m1b_q[2];
      m2_q[8] <= m1b_q[3];
      for (int a = 0; a < 3; a++) begin
        s2_q[a] <= s1_q[a];
      end
    end
  end

  // ---------------- matrix stage 3: sums ----------------
  typedef logic signed [QW+1:0] w_t;
  w_t e_q [9];

  function automatic w_t wx(input q_t v);
    return w_t'(v);
  endfunction

  always_ff @(posedge clk_i) begin
    w_t e [9];
    w_t one;
    if (adv) begin
      one = w_t'(1 <<< FracBits);
      for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? one : '0;
      // m2: 0 cycz 1 cysz 2 sxcy 3 cxcy 4 cxsy 5 cxsz 6 cxcz 7 sycz 8 sxcz
      // t[k] = p[k]*s3 ; p = pair products
      case (ord_q[NC+3])
        ORD_XYZ: begin
          e[0] = wx(m2_q[0]); e[1] = -wx(m2_q[1]); e[2] = wx(s2_q[1]);
          e[3] = wx(p2_q[1]) + wx(t_q[2]); e[4] = wx(p2_q[0]) - wx(t_q[3]);
          e[5] = -wx(m2_q[2]);
          e[6] = wx(p2_q[3]) - wx(t_q[0]); e[7] = wx(p2_q[2]) + wx(t_q[1]);
          e[8] = wx(m2_q[3]);
        end
        ORD_YXZ: begin
          e[0] = wx(p2_q[0]) + wx(t_q[3]); e[1] = wx(t_q[2]) - wx(p2_q[1]);
          e[2] = wx(m2_q[4]); e[3] = wx(m2_q[5]); e[4] = wx(m2_q[6]);
          e[5] = -wx(s2_q[0]);
          e[6] = wx(t_q[1]) - wx(p2_q[2]); e[7] = wx(p2_q[3]) + wx(t_q[0]);
          e[8] = wx(m2_q[3]);
        end
        ORD_ZXY: begin
          e[0] = wx(p2_q[0]) - wx(t_q[3]); e[1] = -wx(m2_q[5]);
          e[2] = wx(p2_q[2]) + wx(t_q[1]);
          e[3] = wx(p2_q[1]) + wx(t_q[2]); e[4] = wx(m2_q[6]);
          e[5] = wx(p2_q[3]) - wx(t_q[0]);
          e[6] = -wx(m2_q[4]); e[7] = wx(s2_q[0]); e[8] = wx(m2_q[3]);
        end
        ORD_ZYX: begin
          e[0] = wx(m2_q[0]); e[1] = wx(t_q[2]) - wx(p2_q[1]);
          e[2] = wx(t_q[0]) + wx(p2_q[3]);
          e[3] = wx(m2_q[1]); e[4] = wx(t_q[3]) + wx(p2_q[0]);
          e[5] = wx(t_q[1]) - wx(p2_q[2]);
          e[6] = -wx(s2_q[1]); e[7] = wx(m2_q[2]); e[8] = wx(m2_q[3]);
        end
        ORD_YZX: begin
          e[0] = wx(m2_q[0]); e[1] = wx(p2_q[3]) - wx(t_q[0]);
          e[2] = wx(t_q[2]) + wx(p2_q[1]);
          e[3] = wx(s2_q[2]); e[4] = wx(m2_q[6]); e[5] = -wx(m2_q[8]);
          e[6] = -wx(m2_q[7]); e[7] = wx(t_q[1]) + wx(p2_q[2]);
          e[8] = wx(p2_q[0]) - wx(t_q[3]);
        end
        ORD_XZY: begin
          e[0] = wx(m2_q[0]); e[1] = -wx(s2_q[2]); e[2] = wx(m2_q[7]);
          e[3] = wx(t_q[0]) + wx(p2_q[3]); e[4] = wx(m2_q[6]);
          e[5] = wx(t_q[1]) - wx(p2_q[2]);
          e[6] = wx(t_q[2]) - wx(p2_q[1]); e[7] = wx(m2_q[8]);
          e[8] = wx(t_q[3]) + wx(p2_q[0]);
        end
        default: ;
      endcase
      for (int k = 0; k < 9; k++) e_q[k] <= e[k];
    end
  end

  // ---------------- matrix stage 4: clamp ----------------
  q_t k_q [9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) k_q[k] <= clamp_q(e_q[k]);
    end
  end

  // ---------------- matrix stage 5: output register ----------------
  logic signed [OutW-1:0] o_q [9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) o_q[k] <= OutW'(k_q[k]);
    end
  end

  assign r0c0_o = o_q[0];
  assign r0c1_o = o_q[1];
  assign r0c2_o = o_q[2];
  assign r1c0_o = o_q[3];
  assign r1c1_o = o_q[4];
  assign r1c2_o = o_q[5];
  assign r2c0_o = o_q[6];
  assign r2c1_o = o_q[7];
  assign r2c2_o = o_q[8];

  // A stalled result keeps its valid bit.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  // Input is only stalled while a result waits.
  `ASSERT_IMPL(a_stall, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  // An accepted item shows up in the first valid stage in the next cycle.
  `ASSERT_NEXT(a_enter, clk_i, rst_ni, in_valid_i && !in_stall_o, vld_q[0])

endmodule
